@@ src/wrce_pkg.sv @@
// ----------------------------------------------------------------------------
// wrce_pkg: shared types and tables for the wireframe rotate/cull block
// Widths, register codes, state types, vertex and face tables.
// ----------------------------------------------------------------------------
package wrce_pkg;

	localparam int VERTEX_COUNT   = 12;
	localparam int FACE_COUNT     = 20;
	localparam int MAX_EDGES      = 30;
	localparam int COORD_FRAC_DEF = 16;

	localparam int VIDX_W     = $clog2(VERTEX_COUNT);
	localparam int FIDX_W     = $clog2(FACE_COUNT);
	localparam int EIDX_W     = $clog2(MAX_EDGES);
	localparam int PIX_W      = 13;
	localparam int POS_W      = 12;
	localparam int SIZE_W     = 10;
	localparam int COEF_W     = 16;
	localparam int MB_W       = 32;
	localparam int RND_SHIFT  = 28;
	localparam int COEF_SHIFT = 14;
	localparam int PIX_MAX_I  = 8191;
	localparam int CFG_IDX_W  = 2;
	localparam int IN_W       = 24;
	localparam int OUT_W      = 56;
	localparam int EDGE_W     = 4 * PIX_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROT_COS = 2'd0,
		CFG_ROT_SIN = 2'd1,
		CFG_BOX_W   = 2'd2,
		CFG_BOX_H   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] rot_cos;
		logic signed [COEF_W-1:0] rot_sin;
		logic [SIZE_W-1:0]        box_width;
		logic [SIZE_W-1:0]        box_height;
	} cfg_t;

	typedef enum logic [2:0] {
		F_IDLE, F_COEF, F_RD, F_MUL, F_ROUND, F_PROJ, F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_LOAD, B_RD0, B_RD1, B_RD2, B_RD3, B_EDGE, B_FLUSH
	} back_state_t;

	localparam int ICO_Q24 [VERTEX_COUNT][3] = '{
		'{        0,         0, -15956080},
		'{        0,  14271552,  -7135776},
		'{ 13573053,   4410152,  -7135776},
		'{  8388608, -11545928,  -7135776},
		'{ -8388608, -11545928,  -7135776},
		'{-13573053,   4410152,  -7135776},
		'{  8388608,  11545928,   7135776},
		'{ 13573053,  -4410152,   7135776},
		'{        0, -14271552,   7135776},
		'{-13573053,  -4410152,   7135776},
		'{ -8388608,  11545928,   7135776},
		'{        0,         0,  15956080}
	};

	localparam logic [VIDX_W-1:0] FACE_V [FACE_COUNT][3] = '{
		'{4'd0, 4'd2, 4'd1},   '{4'd0, 4'd3, 4'd2},  '{4'd0, 4'd4, 4'd3},
		'{4'd0, 4'd5, 4'd4},   '{4'd0, 4'd1, 4'd5},  '{4'd1, 4'd6, 4'd10},
		'{4'd1, 4'd2, 4'd6},   '{4'd2, 4'd7, 4'd6},  '{4'd2, 4'd3, 4'd7},
		'{4'd3, 4'd8, 4'd7},   '{4'd3, 4'd4, 4'd8},  '{4'd4, 4'd9, 4'd8},
		'{4'd4, 4'd5, 4'd9},   '{4'd5, 4'd10, 4'd9}, '{4'd5, 4'd1, 4'd10},
		'{4'd10, 4'd6, 4'd11}, '{4'd6, 4'd7, 4'd11}, '{4'd7, 4'd8, 4'd11},
		'{4'd8, 4'd9, 4'd11},  '{4'd9, 4'd10, 4'd11}
	};

	// undirected edge id of each face edge p0-p1, p1-p2, p2-p0
	localparam logic [EIDX_W-1:0] FACE_E [FACE_COUNT][3] = '{
		'{5'd0, 5'd1, 5'd2},    '{5'd3, 5'd4, 5'd0},    '{5'd5, 5'd6, 5'd3},
		'{5'd7, 5'd8, 5'd5},    '{5'd2, 5'd9, 5'd7},    '{5'd10, 5'd11, 5'd12},
		'{5'd1, 5'd13, 5'd10},  '{5'd14, 5'd15, 5'd13}, '{5'd4, 5'd16, 5'd14},
		'{5'd17, 5'd18, 5'd16}, '{5'd6, 5'd19, 5'd17},  '{5'd20, 5'd21, 5'd19},
		'{5'd8, 5'd22, 5'd20},  '{5'd23, 5'd24, 5'd22}, '{5'd9, 5'd12, 5'd23},
		'{5'd11, 5'd25, 5'd26}, '{5'd15, 5'd27, 5'd25}, '{5'd18, 5'd28, 5'd27},
		'{5'd21, 5'd29, 5'd28}, '{5'd24, 5'd26, 5'd29}
	};

	// reset vertex coordinate, rounded from q24 to frac bits
	function automatic logic signed [25:0] ico_init(input logic [VIDX_W-1:0] vi,
		input logic [1:0] k, input int frac);
		logic signed [25:0] v;
		logic [25:0]        mag;
		int                 sh;
		v   = 26'(ICO_Q24[vi][k]);
		sh  = 24 - frac;
		mag = (v < 0) ? 26'(-v) : 26'(v);
		if (sh > 0) mag = (mag + (26'd1 << (sh - 1))) >> sh;
		return (v < 0) ? -$signed(mag) : $signed(mag);
	endfunction

endpackage

@@ src/wrce_ram.sv @@
// ----------------------------------------------------------------------------
// wrce_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wrce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

@@ src/wrce_fifo.sv @@
// ----------------------------------------------------------------------------
// wrce_fifo: short queue between front and back
// Carries one projected vertex record per transaction.
// ----------------------------------------------------------------------------
module wrce_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    count_q;
	logic             push, pop;

	assign wr_ready = (count_q != CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop) rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wr_data;
	end

endmodule

@@ src/wrce_front.sv @@
// ----------------------------------------------------------------------------
// wrce_front: tick acceptance, vertex rotation and projection
// One shared multiplier steps through the rotation products of each vertex.
// ----------------------------------------------------------------------------
module wrce_front import wrce_pkg::*; #(
	parameter int COORD_FRAC_BITS = COORD_FRAC_DEF,
	parameter int REC_W           = VIDX_W + 2 * PIX_W + COORD_FRAC_BITS + 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,
	output logic             q_valid,
	input  logic             q_ready,
	output logic [REC_W-1:0] q_data
);

	localparam int W   = COORD_FRAC_BITS + 2;
	localparam int AW  = (W > COEF_W) ? W : COEF_W;
	localparam int PRW = AW + MB_W;
	localparam int ACW = PRW + 2;
	localparam int PW  = W + 12;

	localparam logic signed [ACW-1:0] SAT_HI   = ACW'((64'sd1 <<< (W - 1)) - 64'sd1);
	localparam logic signed [ACW-1:0] SAT_LO   = -SAT_HI - ACW'(1);
	localparam logic signed [ACW-1:0] RND_BIAS = ACW'(64'sd1 <<< (RND_SHIFT - 1));
	localparam logic signed [W:0]     ONE      = (W + 1)'(64'sd1 <<< COORD_FRAC_BITS);
	localparam logic signed [PW-1:0]  PMAX     = PW'(PIX_MAX_I);

	front_state_t state_q, nxt_state;
	logic [3:0]        st_q;
	logic [VIDX_W-1:0] vi_q;
	logic [VERTEX_COUNT-1:0] vld_q;
	logic              rd_vld_q;
	logic [POS_W-1:0]  bx_q, by_q;
	logic signed [MB_W-1:0] ss_q, cs_q, cc_q;
	logic signed [AW-1:0]   mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [PRW-1:0]  prod_q;
	logic signed [ACW-1:0]  accx_q, accy_q, accz_q;
	logic signed [W-1:0]    vx, vy, vz, rx, ry, rz;
	logic signed [W-1:0]    rz_q;
	logic signed [PW-1:0]   ppx_q, ppy_q;
	logic signed [PW-1:0]   cpx, cpy, wsz, hsz;
	logic signed [W-1:0]    rx_q, ry_q;
	logic signed [MB_W-1:0] c_ext, s_ext, c14, ns14;
	logic [3*W-1:0]         ram_rdata;
	logic                   ram_re, ram_we;
	logic [PIX_W-1:0]       tx, ty;

	function automatic logic signed [W-1:0] rnd_sat(input logic signed [ACW-1:0] acc);
		logic signed [ACW-1:0] r;
		r = (acc + RND_BIAS) >>> RND_SHIFT;
		if (r > SAT_HI) r = SAT_HI;
		else if (r < SAT_LO) r = SAT_LO;
		return W'(r);
	endfunction

	function automatic logic [PIX_W-1:0] place(input logic signed [PW-1:0] p,
		input logic [POS_W-1:0] pos);
		logic signed [PW-1:0] mag, t, sum;
		if (p < 0) begin
			mag = -p;
			t   = -(mag >>> (COORD_FRAC_BITS + 1));
		end else begin
			mag = p;
			t   = mag >>> (COORD_FRAC_BITS + 1);
		end
		sum = t + PW'($signed({1'b0, pos}));
		if (sum < 0) return '0;
		else if (sum > PMAX) return PMAX[PIX_W-1:0];
		else return sum[PIX_W-1:0];
	endfunction

	wrce_ram #(.WIDTH(3 * W), .DEPTH(VERTEX_COUNT)) u_vram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (vi_q),
		.wdata ({rz, ry, rx}),
		.re    (ram_re),
		.raddr (vi_q),
		.rdata (ram_rdata)
	);

	assign vx = rd_vld_q ? $signed(ram_rdata[W-1:0])     : W'(ico_init(vi_q, 2'd0, COORD_FRAC_BITS));
	assign vy = rd_vld_q ? $signed(ram_rdata[2*W-1:W])   : W'(ico_init(vi_q, 2'd1, COORD_FRAC_BITS));
	assign vz = rd_vld_q ? $signed(ram_rdata[3*W-1:2*W]) : W'(ico_init(vi_q, 2'd2, COORD_FRAC_BITS));

	assign c_ext = MB_W'(cfg.rot_cos);
	assign s_ext = MB_W'(cfg.rot_sin);
	assign c14   = c_ext <<< COEF_SHIFT;
	assign ns14  = (-s_ext) <<< COEF_SHIFT;

	assign rx = rnd_sat(accx_q);
	assign ry = rnd_sat(accy_q);
	assign rz = rnd_sat(accz_q);

	assign cpx = PW'($signed({rx_q[W-1], rx_q}) + ONE);
	assign cpy = PW'($signed({ry_q[W-1], ry_q}) + ONE);
	assign wsz = PW'($signed({1'b0, cfg.box_width}));
	assign hsz = PW'($signed({1'b0, cfg.box_height}));

	assign tx     = place(ppx_q, bx_q);
	assign ty     = place(ppy_q, by_q);
	assign q_data = {rz_q, ty, tx, vi_q};

	always_comb begin
		nxt_state = state_q;
		s_tready  = 1'b0;
		q_valid   = 1'b0;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		mul_a     = AW'(cfg.rot_sin);
		mul_b     = s_ext;
		case (state_q)
			F_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) nxt_state = F_COEF;
			end
			F_COEF: begin
				case (st_q)
					4'd0: begin
						mul_a = AW'(cfg.rot_sin);
						mul_b = s_ext;
					end
					4'd1: begin
						mul_a = AW'(cfg.rot_cos);
						mul_b = s_ext;
					end
					default: begin
						mul_a = AW'(cfg.rot_cos);
						mul_b = c_ext;
					end
				endcase
				if (st_q == 4'd3) nxt_state = F_RD;
			end
			F_RD: begin
				ram_re    = 1'b1;
				nxt_state = F_MUL;
			end
			F_MUL: begin
				case (st_q)
					4'd0: begin
						mul_a = AW'(vx);
						mul_b = c14;
					end
					4'd1: begin
						mul_a = AW'(vy);
						mul_b = ss_q;
					end
					4'd2: begin
						mul_a = AW'(vz);
						mul_b = cs_q;
					end
					4'd3: begin
						mul_a = AW'(vy);
						mul_b = c14;
					end
					4'd4: begin
						mul_a = AW'(vz);
						mul_b = ns14;
					end
					4'd5: begin
						mul_a = AW'(vx);
						mul_b = ns14;
					end
					4'd6: begin
						mul_a = AW'(vy);
						mul_b = cs_q;
					end
					default: begin
						mul_a = AW'(vz);
						mul_b = cc_q;
					end
				endcase
				if (st_q == 4'd8) nxt_state = F_ROUND;
			end
			F_ROUND: begin
				ram_we    = 1'b1;
				nxt_state = F_PROJ;
			end
			F_PROJ: nxt_state = F_PUSH;
			F_PUSH: begin
				q_valid = 1'b1;
				if (q_ready) begin
					nxt_state = (vi_q == VIDX_W'(VERTEX_COUNT - 1)) ? F_IDLE : F_RD;
				end
			end
			default: nxt_state = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			st_q    <= '0;
			vi_q    <= '0;
			vld_q   <= '0;
		end else begin
			state_q <= nxt_state;
			if ((state_q == F_COEF && st_q != 4'd3) || (state_q == F_MUL && st_q != 4'd8))
				st_q <= st_q + 1'b1;
			else
				st_q <= '0;
			if (state_q == F_IDLE) vi_q <= '0;
			else if (state_q == F_PUSH && q_ready) vi_q <= vi_q + 1'b1;
			if (ram_we) vld_q[vi_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * PRW'(mul_b);
		if (s_tvalid && s_tready) begin
			bx_q <= s_tdata[POS_W-1:0];
			by_q <= s_tdata[2*POS_W-1:POS_W];
		end
		if (state_q == F_COEF) begin
			case (st_q)
				4'd1: ss_q <= MB_W'(prod_q);
				4'd2: cs_q <= MB_W'(prod_q);
				4'd3: cc_q <= MB_W'(prod_q);
				default: ;
			endcase
		end
		if (ram_re) rd_vld_q <= vld_q[vi_q];
		if (state_q == F_MUL) begin
			case (st_q)
				4'd1: accx_q <= ACW'(prod_q);
				4'd2, 4'd3: accx_q <= accx_q + ACW'(prod_q);
				4'd4: accy_q <= ACW'(prod_q);
				4'd5: accy_q <= accy_q + ACW'(prod_q);
				4'd6: accz_q <= ACW'(prod_q);
				4'd7, 4'd8: accz_q <= accz_q + ACW'(prod_q);
				default: ;
			endcase
		end
		if (state_q == F_ROUND) begin
			rx_q <= rx;
			ry_q <= ry;
			rz_q <= rz;
		end
		if (state_q == F_PROJ) begin
			ppx_q <= cpx * wsz;
			ppy_q <= cpy * hsz;
		end
	end

endmodule

@@ src/wrce_back.sv @@
// ----------------------------------------------------------------------------
// wrce_back: face walk, culling and edge output
// Loads one frame of projected vertices, then walks the faces in order.
// ----------------------------------------------------------------------------
module wrce_back import wrce_pkg::*; #(
	parameter int COORD_FRAC_BITS = COORD_FRAC_DEF,
	parameter int REC_W           = VIDX_W + 2 * PIX_W + COORD_FRAC_BITS + 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	output logic             q_ready,
	input  logic [REC_W-1:0] q_data,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,
	output logic             m_tlast
);

	localparam int W  = COORD_FRAC_BITS + 2;
	localparam int DW = 2 * PIX_W + W;
	localparam int PP = 2 * PIX_W;

	back_state_t state_q, nxt_state;
	logic [VIDX_W-1:0] cnt_q;
	logic [FIDX_W-1:0] face_q;
	logic [1:0]        edge_q;
	logic [MAX_EDGES-1:0] marks_q;
	logic [PP-1:0]     kp0_q, kp1_q, kp2_q, ap, bp;
	logic signed [W-1:0] kz0_q, kz1_q, kz2_q;
	logic signed [W+1:0] zsum;
	logic [EIDX_W-1:0] eid;
	logic              pend_valid_q, out_valid_q, out_last_q;
	logic [EDGE_W-1:0] pend_q, out_q;
	logic              out_free;
	logic              ram_we, ram_re, pop_done;
	logic [VIDX_W-1:0] raddr;
	logic [DW-1:0]     rdata;
	logic              cap0, cap1, cap2, adv, face_next, emit, flush_emit;

	wrce_ram #(.WIDTH(DW), .DEPTH(VERTEX_COUNT)) u_pram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (q_data[VIDX_W-1:0]),
		.wdata (q_data[REC_W-1:VIDX_W]),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign out_free = !out_valid_q || m_tready;
	assign zsum     = (W + 2)'(kz0_q) + (W + 2)'(kz1_q) + (W + 2)'(kz2_q);
	assign eid      = FACE_E[face_q][edge_q];
	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(OUT_W - EDGE_W){1'b0}}, out_q};

	always_comb begin
		case (edge_q)
			2'd0: begin
				ap = kp0_q;
				bp = kp1_q;
			end
			2'd1: begin
				ap = kp1_q;
				bp = kp2_q;
			end
			default: begin
				ap = kp2_q;
				bp = kp0_q;
			end
		endcase
	end

	always_comb begin
		nxt_state  = state_q;
		q_ready    = 1'b0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		raddr      = FACE_V[face_q][0];
		pop_done   = 1'b0;
		cap0       = 1'b0;
		cap1       = 1'b0;
		cap2       = 1'b0;
		adv        = 1'b0;
		face_next  = 1'b0;
		emit       = 1'b0;
		flush_emit = 1'b0;
		case (state_q)
			B_LOAD: begin
				q_ready = 1'b1;
				if (q_valid) begin
					ram_we = 1'b1;
					if (cnt_q == VIDX_W'(VERTEX_COUNT - 1)) begin
						pop_done  = 1'b1;
						nxt_state = B_RD0;
					end
				end
			end
			B_RD0: begin
				ram_re    = 1'b1;
				raddr     = FACE_V[face_q][0];
				nxt_state = B_RD1;
			end
			B_RD1: begin
				ram_re    = 1'b1;
				raddr     = FACE_V[face_q][1];
				cap0      = 1'b1;
				nxt_state = B_RD2;
			end
			B_RD2: begin
				ram_re    = 1'b1;
				raddr     = FACE_V[face_q][2];
				cap1      = 1'b1;
				nxt_state = B_RD3;
			end
			B_RD3: begin
				cap2      = 1'b1;
				nxt_state = B_EDGE;
			end
			B_EDGE: begin
				if (zsum < 0) begin
					face_next = 1'b1;
				end else if (marks_q[eid]) begin
					adv = 1'b1;
				end else if (!pend_valid_q || out_free) begin
					emit = 1'b1;
					adv  = 1'b1;
				end
				if (adv && edge_q == 2'd2) face_next = 1'b1;
				if (face_next) begin
					nxt_state = (face_q == FIDX_W'(FACE_COUNT - 1)) ? B_FLUSH : B_RD0;
				end
			end
			B_FLUSH: begin
				if (!pend_valid_q) begin
					nxt_state = B_LOAD;
				end else if (out_free) begin
					flush_emit = 1'b1;
					nxt_state  = B_LOAD;
				end
			end
			default: nxt_state = B_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_LOAD;
			cnt_q        <= '0;
			face_q       <= '0;
			edge_q       <= '0;
			marks_q      <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= nxt_state;
			if (ram_we) cnt_q <= pop_done ? '0 : cnt_q + 1'b1;
			if (pop_done) begin
				marks_q <= '0;
				face_q  <= '0;
				edge_q  <= '0;
			end else if (face_next) begin
				edge_q <= '0;
				if (face_q != FIDX_W'(FACE_COUNT - 1)) face_q <= face_q + 1'b1;
			end else if (adv) begin
				edge_q <= edge_q + 1'b1;
			end
			if (emit) marks_q[eid] <= 1'b1;
			if (m_tready) out_valid_q <= 1'b0;
			if ((emit && pend_valid_q) || flush_emit) out_valid_q <= 1'b1;
			if (emit) pend_valid_q <= 1'b1;
			else if (flush_emit) pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cap0) begin
			kp0_q <= rdata[PP-1:0];
			kz0_q <= $signed(rdata[DW-1:PP]);
		end
		if (cap1) begin
			kp1_q <= rdata[PP-1:0];
			kz1_q <= $signed(rdata[DW-1:PP]);
		end
		if (cap2) begin
			kp2_q <= rdata[PP-1:0];
			kz2_q <= $signed(rdata[DW-1:PP]);
		end
		if (emit) pend_q <= {bp, ap};
		if (emit && pend_valid_q) begin
			out_q      <= pend_q;
			out_last_q <= 1'b0;
		end else if (flush_emit) begin
			out_q      <= pend_q;
			out_last_q <= 1'b1;
		end
	end

endmodule

@@ src/wireframe_rotate_cull_edges.sv @@
// ----------------------------------------------------------------------------
// wireframe_rotate_cull_edges: rotating icosahedron with back-face culling
// A tick passes through coefficient setup, then its 12 vertices in turn
// through the shared rotation multiplier, then the face walk, which holds
// one edge back so that the last one can carry m_tlast.
// The tick rate is set by the front's multiplier sequence and the back's
// single-port face walk, which reads the three vertices of a face in turn.
// Reset: asynchronous; clears control, restores the vertex table through
// valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module wireframe_rotate_cull_edges import wrce_pkg::*; #(
	parameter int COORD_FRAC_BITS = COORD_FRAC_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]    cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_W-1:0]      s_tdata,   // box_x, box_y
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata,   // start_x, start_y, end_x, end_y
	output logic                 m_tlast
);

	localparam int REC_W = VIDX_W + 2 * PIX_W + COORD_FRAC_BITS + 2;

	cfg_t             cfg_q;
	logic             q_wvalid, q_wready, q_rvalid, q_rready;
	logic [REC_W-1:0] q_wdata, q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rot_cos    <= 16'sd16322;
			cfg_q.rot_sin    <= 16'sd1428;
			cfg_q.box_width  <= 10'd150;
			cfg_q.box_height <= 10'd150;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROT_COS: cfg_q.rot_cos    <= $signed(cfg_data);
				CFG_ROT_SIN: cfg_q.rot_sin    <= $signed(cfg_data);
				CFG_BOX_W:   cfg_q.box_width  <= cfg_data[SIZE_W-1:0];
				CFG_BOX_H:   cfg_q.box_height <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	wrce_front #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .REC_W(REC_W)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_valid  (q_wvalid),
		.q_ready  (q_wready),
		.q_data   (q_wdata)
	);

	wrce_fifo #(.WIDTH(REC_W), .DEPTH(4)) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (q_wvalid),
		.wr_ready (q_wready),
		.wr_data  (q_wdata),
		.rd_valid (q_rvalid),
		.rd_ready (q_rready),
		.rd_data  (q_rdata)
	);

	wrce_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .REC_W(REC_W)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_rvalid),
		.q_ready  (q_rready),
		.q_data   (q_rdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
